[rtl/mat3_pkg.sv]
// shared types and constants of the 3x3 matrix inverse pipeline
package mat3_pkg;

  localparam int EW   = 32;   // width of one matrix entry
  localparam int NE   = 9;    // entries per matrix
  localparam int PW   = 64;   // product of two entries
  localparam int CW   = 65;   // cofactor
  localparam int TW   = 97;   // one determinant term
  localparam int DETW = 98;   // determinant sum
  localparam int DMW  = 97;   // determinant magnitude
  localparam int QW   = 32;   // quotient bits produced by the divider
  localparam int DIV0 = 8;    // first divider stage
  localparam int NST  = DIV0 + QW + 1;

  localparam logic [QW-1:0] QLIM_POS = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] QLIM_NEG = 32'h8000_0000;

  typedef logic signed [EW-1:0]   elem_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic signed [CW-1:0]   cof_t;
  typedef logic signed [TW-1:0]   term_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic [DMW-1:0]         dmag_t;
  typedef logic [PW-1:0]          cmag_t;
  typedef logic [3:0]             idx_t;

  // one quotient lane of the divider
  typedef struct packed {
    logic          neg;
    logic          big;
    dmag_t         rem;
    logic [QW-1:0] qs;
  } lane_t;

  // divider stage contents, divisor shared by all lanes
  typedef struct packed {
    logic              dzero;
    dmag_t             d;
    lane_t [NE-1:0]    lane;
  } divst_t;

  // cofactor k = a[p]*a[q] - a[r]*a[s], matrix entries row by row
  localparam idx_t COF_IDX [NE][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

endpackage

[rtl/mat3_cof.sv]
// two pipeline stages: entry products, then the nine adjugate cofactors
module mat3_cof (
  input  logic                    clk,
  input  logic [1:0]              en,
  input  mat3_pkg::elem_t [8:0]   a,
  output mat3_pkg::elem_t [2:0]   row0,
  output mat3_pkg::cof_t [8:0]    cof
);
  import mat3_pkg::*;

  prod_t [NE-1:0] pp;
  prod_t [NE-1:0] pn;
  elem_t [2:0]    row0_s1;

  // products of entry pairs
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NE; k++) begin
        pp[k] <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
        pn[k] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
      end
      row0_s1 <= a[2:0];
    end
  end

  // cofactor differences
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NE; k++) begin
        cof[k] <= cof_t'(pp[k]) - cof_t'(pn[k]);
      end
      row0 <= row0_s1;
    end
  end

endmodule

[rtl/mat3_det.sv]
// three pipeline stages: split term products, terms, determinant sum
module mat3_det (
  input  logic                    clk,
  input  logic [2:0]              en,
  input  mat3_pkg::elem_t [2:0]   row0,
  input  mat3_pkg::cof_t [8:0]    cof,
  output mat3_pkg::det_t          det,
  output mat3_pkg::cof_t [8:0]    cof_o
);
  import mat3_pkg::*;

  cof_t [2:0]     plo;
  cof_t [2:0]     phi;
  term_t [2:0]    term;
  cof_t [NE-1:0]  cof3;
  cof_t [NE-1:0]  cof4;

  // partial products of first-row entry and cofactor halves
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= row0[j] * $signed({1'b0, cof[3*j][31:0]});
        phi[j] <= row0[j] * $signed(cof[3*j][CW-1:32]);
      end
      cof3 <= cof;
    end
  end

  // recombine halves into full terms
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= (term_t'(phi[j]) <<< 32) + term_t'(plo[j]);
      end
      cof4 <= cof3;
    end
  end

  // determinant by expansion along the first row
  always_ff @(posedge clk) begin
    if (en[2]) begin
      det   <= det_t'(term[0]) + det_t'(term[1]) + det_t'(term[2]);
      cof_o <= cof4;
    end
  end

endmodule

[rtl/mat3_prep.sv]
// two pipeline stages: sign and magnitude, then divider lane set-up
module mat3_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic [1:0]              en,
  input  mat3_pkg::det_t          det,
  input  mat3_pkg::cof_t [8:0]    cof,
  output mat3_pkg::divst_t        ds
);
  import mat3_pkg::*;

  localparam int NW = PW + 2 * FRAC_BITS;

  det_t              ndet;
  cof_t [NE-1:0]     ncof;
  logic              dneg;
  logic              dzero;
  dmag_t             dmag;
  logic [NE-1:0]     cneg;
  cmag_t [NE-1:0]    cmag;
  logic [NW-1:0]     num [NE];
  divst_t            ds_next;

  // magnitudes
  always_comb begin
    ndet = -det;
    for (int k = 0; k < NE; k++) begin
      ncof[k] = -cof[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dneg  <= det[DETW-1];
      dzero <= (det == '0);
      dmag  <= det[DETW-1] ? ndet[DMW-1:0] : det[DMW-1:0];
      for (int k = 0; k < NE; k++) begin
        cneg[k] <= cof[k][CW-1];
        cmag[k] <= cof[k][CW-1] ? ncof[k][PW-1:0] : cof[k][PW-1:0];
      end
    end
  end

  // scaled numerator, overflow check and first partial remainder
  always_comb begin
    ds_next.dzero = dzero;
    ds_next.d     = dmag;
    for (int k = 0; k < NE; k++) begin
      num[k] = {cmag[k], {(2 * FRAC_BITS){1'b0}}};
      ds_next.lane[k].neg = cneg[k] ^ dneg;
      ds_next.lane[k].big = DMW'(num[k][NW-1:QW]) >= dmag;
      ds_next.lane[k].rem = DMW'(num[k][NW-1:QW]);
      ds_next.lane[k].qs  = num[k][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ds <= ds_next;
    end
  end

endmodule

[rtl/mat3_divstep.sv]
// one restoring division step for all nine lanes
module mat3_divstep (
  input  logic              clk,
  input  logic              en,
  input  mat3_pkg::divst_t  din,
  output mat3_pkg::divst_t  dout
);
  import mat3_pkg::*;

  logic [DMW:0]  r2   [NE];
  logic [DMW:0]  diff [NE];
  logic [NE-1:0] ge;
  divst_t        nxt;

  // shift in next numerator bit, subtract divisor where it fits
  always_comb begin
    nxt.dzero = din.dzero;
    nxt.d     = din.d;
    for (int k = 0; k < NE; k++) begin
      r2[k]   = {din.lane[k].rem, din.lane[k].qs[QW-1]};
      diff[k] = r2[k] - {1'b0, din.d};
      ge[k]   = r2[k] >= {1'b0, din.d};
      nxt.lane[k].neg = din.lane[k].neg;
      nxt.lane[k].big = din.lane[k].big;
      nxt.lane[k].rem = ge[k] ? diff[k][DMW-1:0] : r2[k][DMW-1:0];
      nxt.lane[k].qs  = {din.lane[k].qs[QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

[rtl/matrix3x3_inverse_unit.sv]
// top level of the pipelined 3x3 fixed-point matrix inverse
//
// Takes one matrix of nine signed Q.F entries per item and returns its inverse
// in Q.F, one item per clock while the output is not stalled. Stages in order: input
// register, products, cofactors, three determinant stages, sign/magnitude and
// divider set-up, 32 restoring division steps (one quotient bit each, nine
// lanes side by side sharing the determinant as divisor), and the output
// register. Each stage advances whenever it or any later stage is empty, so
// bubbles close up under output stall and new items keep entering until every
// stage holds one. A zero determinant gives all-zero entries with singular set;
// entries beyond the signed 32-bit range are clipped and flag saturated.
module matrix3x3_inverse_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mat3_pkg::elem_t  a00,
  input  mat3_pkg::elem_t  a01,
  input  mat3_pkg::elem_t  a02,
  input  mat3_pkg::elem_t  a10,
  input  mat3_pkg::elem_t  a11,
  input  mat3_pkg::elem_t  a12,
  input  mat3_pkg::elem_t  a20,
  input  mat3_pkg::elem_t  a21,
  input  mat3_pkg::elem_t  a22,
  output logic             res_valid,
  input  logic             res_stall,
  output mat3_pkg::elem_t  inv00,
  output mat3_pkg::elem_t  inv01,
  output mat3_pkg::elem_t  inv02,
  output mat3_pkg::elem_t  inv10,
  output mat3_pkg::elem_t  inv11,
  output mat3_pkg::elem_t  inv12,
  output mat3_pkg::elem_t  inv20,
  output mat3_pkg::elem_t  inv21,
  output mat3_pkg::elem_t  inv22,
  output logic             singular,
  output logic             saturated
);
  import mat3_pkg::*;

  logic [NST-1:0]  v;
  logic [NST-1:0]  en;
  elem_t [NE-1:0]  a_s0;
  elem_t [2:0]     row0;
  cof_t [NE-1:0]   cof_c;
  cof_t [NE-1:0]   cof_d;
  det_t            det;
  divst_t          ds [QW+1];
  elem_t [NE-1:0]  res_next;
  elem_t [NE-1:0]  res;
  logic [NE-1:0]   clip;
  logic [QW-1:0]   lim [NE];
  logic [QW-1:0]   mag [NE];
  logic            sat_next;

  // a stage moves when the output is not stalled or when it or some later stage is free
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      en[k] = !res_stall || (((~v) >> k) != '0);
    end
  end

  assign item_stall = !en[0];
  assign res_valid  = v[NST-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= item_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_s0 <= {a22, a21, a20, a12, a11, a10, a02, a01, a00};
    end
  end

  mat3_cof u_cof (
    .clk  (clk),
    .en   (en[2:1]),
    .a    (a_s0),
    .row0 (row0),
    .cof  (cof_c)
  );

  mat3_det u_det (
    .clk   (clk),
    .en    (en[5:3]),
    .row0  (row0),
    .cof   (cof_c),
    .det   (det),
    .cof_o (cof_d)
  );

  mat3_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk (clk),
    .en  (en[7:6]),
    .det (det),
    .cof (cof_d),
    .ds  (ds[0])
  );

  // division steps, most significant quotient bit first
  for (genvar j = 0; j < QW; j++) begin : g_div
    mat3_divstep u_step (
      .clk  (clk),
      .en   (en[DIV0+j]),
      .din  (ds[j]),
      .dout (ds[j+1])
    );
  end

  // clipping, sign and singular case
  always_comb begin
    sat_next = 1'b0;
    for (int k = 0; k < NE; k++) begin
      lim[k]  = ds[QW].lane[k].neg ? QLIM_NEG : QLIM_POS;
      clip[k] = ds[QW].lane[k].big || (ds[QW].lane[k].qs > lim[k]);
      mag[k]  = clip[k] ? lim[k] : ds[QW].lane[k].qs;
      if (ds[QW].dzero) begin
        res_next[k] = '0;
      end else begin
        res_next[k] = ds[QW].lane[k].neg ? elem_t'(-mag[k]) : elem_t'(mag[k]);
        sat_next    = sat_next | clip[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      res       <= res_next;
      singular  <= ds[QW].dzero;
      saturated <= sat_next;
    end
  end

  assign inv00 = res[0];
  assign inv01 = res[1];
  assign inv02 = res[2];
  assign inv10 = res[3];
  assign inv11 = res[4];
  assign inv12 = res[5];
  assign inv20 = res[6];
  assign inv21 = res[7];
  assign inv22 = res[8];

  // singular result carries only zeros
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && singular |-> !saturated && inv00 == 0 && inv01 == 0 &&
      inv02 == 0 && inv10 == 0 && inv11 == 0 && inv12 == 0 &&
      inv20 == 0 && inv21 == 0 && inv22 == 0)
    else $error("singular result with nonzero entries");

  // input held back only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (&v))
    else $error("input stalled with a free stage");

  // lane 0 partial remainder stays below the divisor when no overflow
  a_rem_first: assert property (@(posedge clk) disable iff (rst)
    v[DIV0-1] && !ds[0].dzero && !ds[0].lane[0].big |->
      ds[0].lane[0].rem < ds[0].d)
    else $error("initial remainder not below divisor");

  a_rem_last: assert property (@(posedge clk) disable iff (rst)
    v[NST-2] && !ds[QW].dzero && !ds[QW].lane[0].big |->
      ds[QW].lane[0].rem < ds[QW].d)
    else $error("final remainder not below divisor");

endmodule
